[hw/rtl/mte_pkg.sv]
// Shared types and constants of the escape-time pixel evaluator.
package mte_pkg;

    localparam int COORD_W   = 32;               // z and c components, signed
    localparam int PROD_W    = 2 * COORD_W;      // exact product width
    localparam int STEP_W    = 31;               // x_step, y_step, escape_radius_sq
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_IMAGE_WIDTH     = 1024;
    localparam int DEF_IMAGE_HEIGHT    = 1024;
    localparam int DEF_COORD_FRAC_BITS = 28;
    localparam int DEF_ITER_BITS       = 16;

    localparam logic signed [COORD_W-1:0] X_MIN_RESET = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] Y_MIN_RESET = -32'sd402653184;
    localparam logic [STEP_W-1:0] X_STEP_RESET    = 31'd786432;
    localparam logic [STEP_W-1:0] Y_STEP_RESET    = 31'd786432;
    localparam logic [STEP_W-1:0] RADIUS_SQ_RESET = 31'd1073741824;
    localparam int unsigned       MAX_ITER_RESET  = 256;

    localparam logic [CFG_ADDR_W-1:0] CFG_X_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_MIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_SQ = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MAP_MUL  = 6'b000010,
        ST_MAP_ADD  = 6'b000100,
        ST_ITER_MUL = 6'b001000,
        ST_ITER_UPD = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic count_lt_max;
        logic escaped;
    } status_t;

endpackage

[hw/rtl/mandelbrot_escape_time.sv]
// Top level of the escape-time pixel evaluator: controller plus datapath.
//
// Each s_ transaction carries one pixel (column, row). The block maps it to
// c = (x_min + pixel_x*x_step) + i*(y_min + pixel_y*y_step) in signed fixed
// point with COORD_FRAC_BITS fraction bits, clamping each part to 32 bits,
// then iterates z = z*z + c from z = c while |z|^2 <= escape_radius_sq and
// fewer than max_iter steps have run. One m_ transaction returns the step
// count and in_set, which is high when the count reached max_iter.
// Timing: one pixel at a time. An accepted pixel passes the map multiply
// and map add, then each step uses the three parallel 32x32 multipliers and
// then the escape compare and z update; the finish state loads the result.
// The next pixel is taken at the earliest in the cycle after the result is
// loaded. A new pixel is taken while a finished result still waits in the
// output register; the evaluator stalls only when a second result is ready
// before the first is taken.
// Configuration: write cfg_wdata to register cfg_addr with cfg_we high, only
// while no pixel is in flight. Index 0 x_min, 1 y_min, 2 x_step, 3 y_step,
// 4 max_iter, 5 escape_radius_sq; other indexes are ignored.
module mandelbrot_escape_time #(
    parameter int IMAGE_WIDTH     = mte_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT    = mte_pkg::DEF_IMAGE_HEIGHT,
    parameter int COORD_FRAC_BITS = mte_pkg::DEF_COORD_FRAC_BITS,
    parameter int ITER_BITS       = mte_pkg::DEF_ITER_BITS,
    // pixel index widths follow from the image size
    parameter int PX_W = (IMAGE_WIDTH  > 1) ? $clog2(IMAGE_WIDTH)  : 1,
    parameter int PY_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [mte_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mte_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [PX_W-1:0]                s_pixel_x,
    input  logic [PY_W-1:0]                s_pixel_y,
    // result output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ITER_BITS-1:0]           m_iter_count,
    output logic                           m_in_set
);

    mte_pkg::cmd_t    cmd;
    mte_pkg::status_t status;

    // sequencer: owns both handshakes and steps the datapath
    mte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: configuration registers, mapping, iteration, result register
    mte_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ITER_BITS       (ITER_BITS),
        .PX_W            (PX_W),
        .PY_W            (PY_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .cmd          (cmd),
        .status       (status),
        .m_iter_count (m_iter_count),
        .m_in_set     (m_in_set)
    );

endmodule

[hw/rtl/mte_ctrl.sv]
// Sequencer of the escape-time evaluator: handshakes and per-step commands.
module mte_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  mte_pkg::status_t status,
    output mte_pkg::cmd_t    cmd
);

    mte_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == mte_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            mte_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_pixel = 1'b1;
                    state_next     = mte_pkg::ST_MAP_MUL;
                end
            end
            mte_pkg::ST_MAP_MUL: begin
                cmd.map_mul = 1'b1;
                state_next  = mte_pkg::ST_MAP_ADD;
            end
            mte_pkg::ST_MAP_ADD: begin
                cmd.map_add = 1'b1;
                state_next  = mte_pkg::ST_ITER_MUL;
            end
            mte_pkg::ST_ITER_MUL: begin
                if (status.count_lt_max) begin
                    cmd.iter_mul = 1'b1;
                    state_next   = mte_pkg::ST_ITER_UPD;
                end else begin
                    state_next = mte_pkg::ST_FINISH;
                end
            end
            mte_pkg::ST_ITER_UPD: begin
                if (status.escaped) begin
                    state_next = mte_pkg::ST_FINISH;
                end else begin
                    cmd.iter_upd = 1'b1;
                    state_next   = mte_pkg::ST_ITER_MUL;
                end
            end
            mte_pkg::ST_FINISH: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mte_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mte_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/mte_datapath.sv]
// Datapath of the escape-time evaluator: registers, mapping and z iteration.
module mte_datapath #(
    parameter int COORD_FRAC_BITS = mte_pkg::DEF_COORD_FRAC_BITS,
    parameter int ITER_BITS       = mte_pkg::DEF_ITER_BITS,
    parameter int PX_W            = 10,
    parameter int PY_W            = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mte_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mte_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [PX_W-1:0]                   s_pixel_x,
    input  logic [PY_W-1:0]                   s_pixel_y,
    input  mte_pkg::cmd_t                     cmd,
    output mte_pkg::status_t                  status,
    output logic [ITER_BITS-1:0]              m_iter_count,
    output logic                              m_in_set
);

    localparam int CW  = mte_pkg::COORD_W;
    localparam int PW  = mte_pkg::PROD_W;
    localparam int SW  = mte_pkg::STEP_W;
    localparam int OXW = PX_W + SW;
    localparam int OYW = PY_W + SW;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] v);
        logic signed [CW-1:0] r;
        if (v[PW-1:CW-1] == '0 || v[PW-1:CW-1] == '1) begin
            r = v[CW-1:0];
        end else if (v[PW-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic signed [CW-1:0]  x_min_reg, y_min_reg;
    logic [SW-1:0]         x_step_reg, y_step_reg, radius_sq_reg;
    logic [ITER_BITS-1:0]  max_iter_reg;

    // working registers
    logic [PX_W-1:0]       px_reg;
    logic [PY_W-1:0]       py_reg;
    logic [OXW-1:0]        offx_reg;
    logic [OYW-1:0]        offy_reg;
    logic signed [CW-1:0]  cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [CW-1:0]  zr_next, zi_next;
    logic signed [PW-1:0]  rr_reg, ii_reg, ri_reg;
    logic [ITER_BITS-1:0]  count_reg;
    logic [ITER_BITS-1:0]  out_count_reg;
    logic                  out_in_set_reg;

    logic signed [PW-1:0]  map_x_sum, map_y_sum;
    logic [PW-1:0]         mag_sum, mag;
    logic signed [PW-1:0]  re_diff, re_sum, im_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg     <= mte_pkg::X_MIN_RESET;
            y_min_reg     <= mte_pkg::Y_MIN_RESET;
            x_step_reg    <= mte_pkg::X_STEP_RESET;
            y_step_reg    <= mte_pkg::Y_STEP_RESET;
            max_iter_reg  <= ITER_BITS'(mte_pkg::MAX_ITER_RESET);
            radius_sq_reg <= mte_pkg::RADIUS_SQ_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                mte_pkg::CFG_X_MIN:     x_min_reg     <= cfg_wdata;
                mte_pkg::CFG_Y_MIN:     y_min_reg     <= cfg_wdata;
                mte_pkg::CFG_X_STEP:    x_step_reg    <= cfg_wdata[SW-1:0];
                mte_pkg::CFG_Y_STEP:    y_step_reg    <= cfg_wdata[SW-1:0];
                mte_pkg::CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[ITER_BITS-1:0];
                mte_pkg::CFG_RADIUS_SQ: radius_sq_reg <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // c = min + pixel * step, exact then clamped
    assign map_x_sum = {{(PW-CW){x_min_reg[CW-1]}}, x_min_reg}
                     + $signed({{(PW-OXW){1'b0}}, offx_reg});
    assign map_y_sum = {{(PW-CW){y_min_reg[CW-1]}}, y_min_reg}
                     + $signed({{(PW-OYW){1'b0}}, offy_reg});

    // both squares are nonnegative, so the unsigned sum cannot wrap
    assign mag_sum = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign mag     = mag_sum >> COORD_FRAC_BITS;

    // keep every operand signed so the shifts stay arithmetic
    assign re_diff = rr_reg - ii_reg;
    assign re_sum  = (re_diff >>> COORD_FRAC_BITS)
                   + $signed({{(PW-CW){cr_reg[CW-1]}}, cr_reg});
    assign im_sum  = (ri_reg >>> (COORD_FRAC_BITS - 1))
                   + $signed({{(PW-CW){ci_reg[CW-1]}}, ci_reg});
    assign zr_next = sat_coord(re_sum);
    assign zi_next = sat_coord(im_sum);

    assign status.escaped      = mag > {{(PW-SW){1'b0}}, radius_sq_reg};
    assign status.count_lt_max = count_reg < max_iter_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            px_reg <= s_pixel_x;
            py_reg <= s_pixel_y;
        end
        if (cmd.map_mul) begin
            offx_reg <= OXW'(px_reg) * OXW'(x_step_reg);
            offy_reg <= OYW'(py_reg) * OYW'(y_step_reg);
        end
        if (cmd.map_add) begin
            cr_reg    <= sat_coord(map_x_sum);
            ci_reg    <= sat_coord(map_y_sum);
            zr_reg    <= sat_coord(map_x_sum);
            zi_reg    <= sat_coord(map_y_sum);
            count_reg <= '0;
        end
        if (cmd.iter_mul) begin
            rr_reg <= PW'(zr_reg) * PW'(zr_reg);
            ii_reg <= PW'(zi_reg) * PW'(zi_reg);
            ri_reg <= PW'(zr_reg) * PW'(zi_reg);
        end
        if (cmd.iter_upd) begin
            zr_reg    <= zr_next;
            zi_reg    <= zi_next;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_count_reg  <= count_reg;
            out_in_set_reg <= (count_reg == max_iter_reg);
        end
    end

    assign m_iter_count = out_count_reg;
    assign m_in_set     = out_in_set_reg;

endmodule

[verif/tb_mandelbrot_escape_time.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the escape-time pixel evaluator: directed table, then random phases.
module tb_mandelbrot_escape_time;

    localparam int FRAC           = mte_pkg::DEF_COORD_FRAC_BITS;
    localparam int PIX_W          = $clog2(mte_pkg::DEF_IMAGE_WIDTH);
    localparam int PIY_W          = $clog2(mte_pkg::DEF_IMAGE_HEIGHT);
    localparam int CNT_W          = mte_pkg::DEF_ITER_BITS;
    localparam int ADDR_W         = mte_pkg::CFG_ADDR_W;
    localparam int DATA_W         = mte_pkg::CFG_DATA_W;
    localparam int NUM_PHASES     = 16;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRESSURE_PHASE = 2;     // receiver holds off at the start of this phase
    localparam int CALM_FIRST     = 5;     // both sides stream without idling in these phases
    localparam int CALM_LAST      = 6;
    localparam int HOLD_CYCLES    = 3000;
    localparam int IDLE_PCT       = 31;
    localparam int DRAIN_CYCLES   = 8;     // margin after the last result before a write
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    // Q4.28 constants used by the directed table
    localparam logic [31:0] Q_FOUR     = 32'd1073741824;   // 4.0
    localparam logic [31:0] Q_ONE_NINE = 32'd510027366;    // about 1.9
    localparam logic [31:0] Q_DEF_STEP = 32'd786432;       // 3.0 / 1024

    typedef struct packed {
        logic [CNT_W-1:0] iter_count;
        logic             in_set;
    } pixel_result_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIY_W-1:0] py;
        logic             typed;   // use the hand-written result instead of the predictor
        pixel_result_t    want;
    } pixel_item_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        pixel_item_t        item;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [ADDR_W-1:0]     cfg_addr  = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_x = '0;
    logic [PIY_W-1:0]      s_pixel_y = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [CNT_W-1:0]      m_iter_count;
    logic                  m_in_set;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mandelbrot_escape_time uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iter_count (m_iter_count),
        .m_in_set     (m_in_set)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the register file, updated as each write is issued
    // ------------------------------------------------------------------
    logic signed [31:0] x_min_r    = mte_pkg::X_MIN_RESET;
    logic signed [31:0] y_min_r    = mte_pkg::Y_MIN_RESET;
    logic [30:0]        x_step_r   = mte_pkg::X_STEP_RESET;
    logic [30:0]        y_step_r   = mte_pkg::Y_STEP_RESET;
    logic [15:0]        max_iter_r = 16'(mte_pkg::MAX_ITER_RESET);
    logic [30:0]        radius_r   = mte_pkg::RADIUS_SQ_RESET;

    pixel_item_t   pixel_queue[$];     // pixels waiting to be offered
    pixel_result_t result_queue[$];    // escape counts owed by the block, oldest first
    stim_row_t     dir_table[$];

    int     phase_no      = -1;
    int     src_idle_pct  = IDLE_PCT;
    int     snk_idle_pct  = IDLE_PCT;
    int     errors        = 0;
    int     results_seen  = 0;
    int     hold_left     = 0;
    bit     pressure_done = 1'b0;
    longint cycle_count   = 0;
    pixel_result_t sink_want;

    // ------------------------------------------------------------------
    // Escape-time predictor
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > SAT_HI) return 32'sh7FFFFFFF;
        if (v < SAT_LO) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Map a pixel index to one axis of c; the exact sum is clamped, never wrapped.
    function automatic logic signed [31:0] map_axis(input logic signed [31:0] base,
                                                    input logic [30:0] step,
                                                    input logic [9:0] pix);
        longint b, s, p;
        b = base;
        s = step;
        p = pix;
        return clamp32(b + s * p);
    endfunction

    function automatic pixel_result_t escape_count_of(input logic [PIX_W-1:0] px,
                                                      input logic [PIY_W-1:0] py);
        longint        cr, ci, zr, zi, rr, ii, ri;
        logic [63:0]   mag;
        logic [31:0]   steps;
        pixel_result_t r;
        cr = map_axis(x_min_r, x_step_r, px);
        ci = map_axis(y_min_r, y_step_r, py);
        zr = cr;
        zi = ci;
        steps = 0;
        while (steps < max_iter_r) begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            // the sum may reach 2^63; take it as an unsigned pattern
            mag = rr + ii;
            mag = mag >> FRAC;
            if (mag > radius_r) break;
            // arithmetic shifts round toward minus infinity; 2*zr*zi uses one bit less
            zr = clamp32(((rr - ii) >>> FRAC) + cr);
            zi = clamp32((ri >>> (FRAC - 1)) + ci);
            steps++;
        end
        r.iter_count = steps[CNT_W-1:0];
        r.in_set     = (steps == max_iter_r);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pixel source: hold valid and payload until the transaction completes
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // predict from what the block actually took
                if (pixel_queue[0].typed) begin
                    result_queue.push_back(pixel_queue[0].want);
                end else begin
                    result_queue.push_back(escape_count_of(s_pixel_x, s_pixel_y));
                end
                pixel_queue.delete(0);
            end
            // advance only when the channel is free; a pending item stays put
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_pixel_x <= pixel_queue[0].px;
                    s_pixel_y <= pixel_queue[0].py;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: compare each transaction against the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result %0d: iter_count %0d in_set %0b",
                                 results_seen, m_iter_count, m_in_set);
                    errors++;
                end else begin
                    sink_want = result_queue.pop_front();
                    if (m_iter_count !== sink_want.iter_count ||
                        m_in_set !== sink_want.in_set) begin
                        if (errors < 10)
                            $display({"mismatch on result %0d: iter_count exp %0d got %0d,",
                                      " in_set exp %0b got %0b"},
                                     results_seen, sink_want.iter_count, m_iter_count,
                                     sink_want.in_set, m_in_set);
                        errors++;
                    end
                end
                results_seen++;
            end
            // long hold-off once, so the block fills up and stalls its input
            if (phase_no == PRESSURE_PHASE && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Wait until every offered pixel has been answered, then let the block settle.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || s_valid || result_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register while idle and mirror it in the shadow copy.
    task automatic write_reg(input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        wait_drained();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            mte_pkg::CFG_X_MIN:     x_min_r    = data;
            mte_pkg::CFG_Y_MIN:     y_min_r    = data;
            mte_pkg::CFG_X_STEP:    x_step_r   = data[30:0];
            mte_pkg::CFG_Y_STEP:    y_step_r   = data[30:0];
            mte_pkg::CFG_MAX_ITER:  max_iter_r = data[15:0];
            mte_pkg::CFG_RADIUS_SQ: radius_r   = data[30:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic stim_row_t reg_row(input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    // A pixel row; with typed set the escape count is given by hand.
    function automatic stim_row_t pix_row(input int px, input int py, input bit typed,
                                          input int cnt, input bit in_set);
        stim_row_t r;
        r                      = '0;
        r.kind                 = ROW_PIXEL;
        r.item.px              = px[PIX_W-1:0];
        r.item.py              = py[PIY_W-1:0];
        r.item.typed           = typed;
        r.item.want.iter_count = cnt[CNT_W-1:0];
        r.item.want.in_set     = in_set;
        return r;
    endfunction

    // Pick a fresh register setting for one random phase.
    task automatic random_setup();
        logic [31:0] xm, ym, xs, ys, rad, mi_word;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            // window over the interesting region, wide or zoomed in
            xm  = -671088640 + $urandom_range(0, 805306368);
            ym  = -402653184 + $urandom_range(0, 536870912);
            xs  = (kind < 5) ? $urandom_range(0, 786432) : $urandom_range(0, 4096);
            ys  = (kind < 5) ? $urandom_range(0, 786432) : $urandom_range(0, 4096);
            xs[31] = 1'($urandom_range(0, 1));
            ys[31] = 1'($urandom_range(0, 1));
            rad = ($urandom_range(0, 3) != 0) ? Q_FOUR : $urandom;
        end else begin
            // anything goes: mostly instant escapes and clamped coordinates
            xm  = $urandom;
            ym  = $urandom;
            xs  = $urandom;
            ys  = $urandom;
            rad = $urandom;
        end
        mi_word        = $urandom;
        mi_word[15:0]  = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(4, 64));
        write_reg(mte_pkg::CFG_X_MIN, xm);
        write_reg(mte_pkg::CFG_Y_MIN, ym);
        write_reg(mte_pkg::CFG_X_STEP, xs);
        write_reg(mte_pkg::CFG_Y_STEP, ys);
        write_reg(mte_pkg::CFG_MAX_ITER, mi_word);
        write_reg(mte_pkg::CFG_RADIUS_SQ, rad);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        pixel_item_t item;

        // Directed table. Register values after reset: window -2.0..1.0, -1.5..1.5,
        // 256 steps, radius 4.0.
        dir_table.push_back(pix_row(0, 0, 1, 0, 0));          // corner escapes at once
        dir_table.push_back(pix_row(512, 512, 1, 256, 1));    // c = -0.5 stays bounded
        dir_table.push_back(pix_row(1023, 1023, 0, 0, 0));
        dir_table.push_back(pix_row(1023, 0, 0, 0, 0));
        dir_table.push_back(pix_row(0, 1023, 0, 0, 0));
        dir_table.push_back(pix_row(341, 512, 0, 0, 0));
        dir_table.push_back(pix_row(700, 300, 0, 0, 0));
        // zero limit: no step runs, flag always set
        dir_table.push_back(reg_row(mte_pkg::CFG_MAX_ITER, 32'd0));
        dir_table.push_back(pix_row(0, 0, 1, 0, 1));
        dir_table.push_back(pix_row(512, 512, 1, 0, 1));
        dir_table.push_back(pix_row(1023, 1023, 1, 0, 1));
        // single step limit
        dir_table.push_back(reg_row(mte_pkg::CFG_MAX_ITER, 32'd1));
        dir_table.push_back(pix_row(512, 512, 1, 1, 1));
        dir_table.push_back(pix_row(0, 0, 1, 0, 0));
        // coordinate overflow: extreme bases, largest steps and radius, upper bits masked off
        dir_table.push_back(reg_row(mte_pkg::CFG_MAX_ITER, 32'd20));
        dir_table.push_back(reg_row(mte_pkg::CFG_X_MIN, 32'h7FFF_FFFF));
        dir_table.push_back(reg_row(mte_pkg::CFG_X_STEP, 32'hFFFF_FFFF));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_MIN, 32'h8000_0000));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_STEP, 32'h7FFF_FFFF));
        dir_table.push_back(reg_row(mte_pkg::CFG_RADIUS_SQ, 32'hFFFF_FFFF));
        dir_table.push_back(pix_row(1023, 1023, 0, 0, 0));
        dir_table.push_back(pix_row(0, 0, 0, 0, 0));
        dir_table.push_back(pix_row(1, 1, 0, 0, 0));
        // z update clamps: c near (1.9, 1.9) with the widest radius, zero steps
        dir_table.push_back(reg_row(mte_pkg::CFG_X_MIN, Q_ONE_NINE));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_MIN, Q_ONE_NINE));
        dir_table.push_back(reg_row(mte_pkg::CFG_X_STEP, 32'd0));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_STEP, 32'd0));
        dir_table.push_back(pix_row(0, 0, 0, 0, 0));
        dir_table.push_back(pix_row(1023, 1023, 0, 0, 0));
        dir_table.push_back(reg_row(mte_pkg::CFG_X_MIN, 32'd0));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_MIN, 32'd0));
        dir_table.push_back(pix_row(0, 0, 0, 0, 0));
        // zero radius: c = 0 never exceeds it, so the limit is reached
        dir_table.push_back(reg_row(mte_pkg::CFG_RADIUS_SQ, 32'd0));
        dir_table.push_back(pix_row(0, 0, 1, 20, 1));
        // largest limit, one pixel only
        dir_table.push_back(reg_row(mte_pkg::CFG_MAX_ITER, 32'd65535));
        dir_table.push_back(pix_row(0, 0, 1, 65535, 1));
        // reset steps and radius again with a short limit; both bases stay at zero
        dir_table.push_back(reg_row(mte_pkg::CFG_RADIUS_SQ, Q_FOUR));
        dir_table.push_back(reg_row(mte_pkg::CFG_X_STEP, Q_DEF_STEP));
        dir_table.push_back(reg_row(mte_pkg::CFG_Y_STEP, Q_DEF_STEP));
        dir_table.push_back(reg_row(mte_pkg::CFG_MAX_ITER, 32'd32));
        dir_table.push_back(pix_row(1023, 511, 0, 0, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the table; writes wait for the block to drain, pixels stream
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_WRITE) begin
                write_reg(dir_table[i].addr, dir_table[i].data);
            end else begin
                pixel_queue.push_back(dir_table[i].item);
            end
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            random_setup();
            if (ph >= CALM_FIRST && ph <= CALM_LAST) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = IDLE_PCT;
                snk_idle_pct = IDLE_PCT;
            end
            phase_no = ph;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                item       = '0;
                item.px    = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
                item.py    = PIY_W'($urandom_range(0, (1 << PIY_W) - 1));
                pixel_queue.push_back(item);
            end
        end

        wait_drained();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
